/* rtl/odd_even_transposition_sorter_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_MACROS_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_MACROS_SVH

// Check that cond in one cycle is followed by conseq in the next.
`define OETS_ASSERT_NEXT(lbl, clk, rst, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

// Check that expr never holds outside reset.
`define OETS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* rtl/oets_pkg.sv */
`timescale 1ns / 1ps

package oets_pkg;

  localparam int DATA_W            = 32;
  localparam int DEFAULT_MAX_COUNT = 64;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_DRAIN
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       odd_phase;
  } cell_ctrl_t;

endpackage

/* rtl/oets_cell.sv */
`timescale 1ns / 1ps

module oets_cell #(
  parameter bit ODD_INDEX = 1'b0
) (
  input  logic                                 clk,
  input  oets_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [oets_pkg::DATA_W-1:0]   left_value,
  input  logic signed [oets_pkg::DATA_W-1:0]   right_value,
  input  logic                                 pair_left_ok,
  input  logic                                 pair_right_ok,
  output logic signed [oets_pkg::DATA_W-1:0]   value
);

  logic                                left_role;
  logic signed [oets_pkg::DATA_W-1:0]  sort_next;

  // Even phase pairs an even cell with its right neighbor, odd phase an odd one.
  assign left_role = (ODD_INDEX == ctrl.odd_phase);

  always_comb begin
    sort_next = value;
    if (left_role) begin
      if (pair_right_ok && (value > right_value)) sort_next = right_value;
    end else begin
      if (pair_left_ok && (left_value > value)) sort_next = left_value;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      oets_pkg::CELL_LOAD:  value <= left_value;
      oets_pkg::CELL_SORT:  value <= sort_next;
      oets_pkg::CELL_DRAIN: value <= right_value;
      default:              value <= value;
    endcase
  end

endmodule

/* rtl/oets_ctrl.sv */
`timescale 1ns / 1ps

module oets_ctrl #(
  parameter  int MAX_COUNT = oets_pkg::DEFAULT_MAX_COUNT,
  localparam int COUNT_W   = $clog2(MAX_COUNT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tlast,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  m_tlast,
  output oets_pkg::cell_ctrl_t  cell_ctrl,
  output logic [COUNT_W-1:0]    count
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] phase;
  logic               full;

  assign full = (count == COUNT_W'(MAX_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            // drop beats once the row is full
            if (!full) count <= count + COUNT_W'(1);
            if (s_tlast) begin
              state <= ST_SORT;
              phase <= '0;
            end
          end
        end
        ST_SORT: begin
          phase <= phase + COUNT_W'(1);
          if (phase == count - COUNT_W'(1)) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (m_tready) begin
            count <= count - COUNT_W'(1);
            if (count == COUNT_W'(1)) state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_DRAIN);
  assign m_tlast  = m_tvalid && (count == COUNT_W'(1));

  always_comb begin
    cell_ctrl.odd_phase = phase[0];
    case (state)
      ST_LOAD:  cell_ctrl.mode = (s_tvalid && !full) ? oets_pkg::CELL_LOAD
                                                     : oets_pkg::CELL_HOLD;
      ST_SORT:  cell_ctrl.mode = oets_pkg::CELL_SORT;
      ST_DRAIN: cell_ctrl.mode = m_tready ? oets_pkg::CELL_DRAIN : oets_pkg::CELL_HOLD;
      default:  cell_ctrl.mode = oets_pkg::CELL_HOLD;
    endcase
  end

endmodule

/* rtl/odd_even_transposition_sorter.sv */
`timescale 1ns / 1ps

// Sorts a set of up to MAX_COUNT signed 32-bit values ascending. Values enter
// on the s_ side one beat per cycle, the beat with s_tlast closing the set;
// beats past MAX_COUNT are dropped, though their tlast still closes the set.
// The values sit in a row of MAX_COUNT compare-exchange cells. After the
// closing beat the row runs n odd-even transposition phases, one phase per
// cycle across all cells (n = values in the set), then shifts the sorted
// values out on the m_ side one beat per cycle while m_tready is high,
// smallest first, m_tlast on the largest. A set of n values is therefore
// loaded, sorted and then drained as n result beats; no input is taken
// from the closing beat until the last result beat is accepted.
module odd_even_transposition_sorter #(
  parameter int MAX_COUNT = oets_pkg::DEFAULT_MAX_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [oets_pkg::DATA_W-1:0]   s_tdata,   // [31:0] value
  input  logic                          s_tlast,   // last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [oets_pkg::DATA_W-1:0]   m_tdata,   // [31:0] sorted_value
  output logic                          m_tlast    // final_res
);

  localparam int COUNT_W = $clog2(MAX_COUNT + 1);

  oets_pkg::cell_ctrl_t               cell_ctrl;
  logic [COUNT_W-1:0]                 count;
  logic [MAX_COUNT:1]                 active;
  logic signed [oets_pkg::DATA_W-1:0] vals [MAX_COUNT];

  oets_ctrl #(
    .MAX_COUNT (MAX_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tlast   (s_tlast),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .cell_ctrl (cell_ctrl),
    .count     (count)
  );

  // a cell takes part in compares only while it holds a loaded value
  for (genvar i = 1; i <= MAX_COUNT; i++) begin : g_active
    assign active[i] = (COUNT_W'(i) < count);
  end

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    logic signed [oets_pkg::DATA_W-1:0] left_value;
    logic signed [oets_pkg::DATA_W-1:0] right_value;
    logic                               pair_left_ok;

    if (i == 0) begin : g_head
      assign left_value   = s_tdata;
      assign pair_left_ok = 1'b0;
    end else begin : g_body
      assign left_value   = vals[i-1];
      assign pair_left_ok = active[i];
    end

    if (i == MAX_COUNT - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = vals[i+1];
    end

    oets_cell #(
      .ODD_INDEX ((i % 2) == 1)
    ) u_cell (
      .clk           (clk),
      .ctrl          (cell_ctrl),
      .left_value    (left_value),
      .right_value   (right_value),
      .pair_left_ok  (pair_left_ok),
      .pair_right_ok (active[i+1]),
      .value         (vals[i])
    );
  end

  assign m_tdata = vals[0];

endmodule

/* rtl/oets_checker.sv */
`timescale 1ns / 1ps

`include "odd_even_transposition_sorter_macros.svh"

module oets_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [oets_pkg::DATA_W-1:0]  m_tdata,
  input logic                         m_tlast
);

  `OETS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast),
                    "result beat changed while stalled")
  `OETS_ASSERT_NEVER(a_no_overlap, clk, rst, s_tready && m_tvalid,
                     "input open while results pending")
  `OETS_ASSERT_NEXT(a_close_set, clk, rst, s_tvalid && s_tready && s_tlast,
                    !s_tready && !m_tvalid, "closing beat did not start the sort")
  `OETS_ASSERT_NEXT(a_end_drain, clk, rst, m_tvalid && m_tready && m_tlast,
                    !m_tvalid && s_tready, "drain did not end after last beat")

endmodule

bind odd_even_transposition_sorter oets_checker u_oets_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
